// ----- design/stch_pkg.sv -----
`default_nettype none
package stch_pkg;

  // Default sizes
  localparam int COORD_WIDTH_DEF     = 24;
  localparam int PARAM_FRAC_BITS_DEF = 16;

  // Multiplier digit width of the back end and length of the product program
  localparam int DIGIT_BITS      = 16;
  localparam int NUM_TERMS       = 24;
  localparam int TERM_IDX_WIDTH  = 5;
  localparam int CFG_INDEX_WIDTH = 3;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_START_X = 3'd0,
    CFG_START_Y = 3'd1,
    CFG_START_Z = 3'd2,
    CFG_END_X   = 3'd3,
    CFG_END_Y   = 3'd4,
    CFG_END_Z   = 3'd5
  } cfg_reg_t;

  // Operand codes: edge and segment differences, then normal and qp x ap cross terms
  typedef enum logic [4:0] {
    OP_AB0 = 5'd0,  OP_AB1 = 5'd1,  OP_AB2 = 5'd2,
    OP_AC0 = 5'd3,  OP_AC1 = 5'd4,  OP_AC2 = 5'd5,
    OP_QP0 = 5'd6,  OP_QP1 = 5'd7,  OP_QP2 = 5'd8,
    OP_AP0 = 5'd9,  OP_AP1 = 5'd10, OP_AP2 = 5'd11,
    OP_N0  = 5'd12, OP_N1  = 5'd13, OP_N2  = 5'd14,
    OP_E0  = 5'd15, OP_E1  = 5'd16, OP_E2  = 5'd17
  } opnd_t;

  // Where a finished sum of products goes
  typedef enum logic [3:0] {
    DST_NONE, DST_N0, DST_N1, DST_N2, DST_D, DST_NUM,
    DST_E0, DST_E1, DST_E2, DST_V, DST_W
  } dst_t;

  // One product term: acc = (first ? 0 : acc) +/- a * b
  typedef struct packed {
    opnd_t a_sel;
    opnd_t b_sel;
    logic  sub;
    logic  first;
    logic  last;
    dst_t  dst;
  } term_t;

  // Back end state machine
  typedef enum logic [2:0] {
    BK_IDLE, BK_LOAD, BK_MUL, BK_CHECK, BK_DIV, BK_FIN
  } bk_state_t;

  // Product program: n = ab x ac, d = qp.n, num = ap.n, e = qp x ap,
  // v = ac.e, w = -(ab.e)
  function automatic term_t term_entry(input logic [TERM_IDX_WIDTH-1:0] idx);
    term_t t;
    t = '{OP_AB0, OP_AB0, 1'b0, 1'b1, 1'b0, DST_NONE};
    unique case (idx)
      5'd0:  t = '{OP_AB1, OP_AC2, 1'b0, 1'b1, 1'b0, DST_NONE};
      5'd1:  t = '{OP_AB2, OP_AC1, 1'b1, 1'b0, 1'b1, DST_N0};
      5'd2:  t = '{OP_AB2, OP_AC0, 1'b0, 1'b1, 1'b0, DST_NONE};
      5'd3:  t = '{OP_AB0, OP_AC2, 1'b1, 1'b0, 1'b1, DST_N1};
      5'd4:  t = '{OP_AB0, OP_AC1, 1'b0, 1'b1, 1'b0, DST_NONE};
      5'd5:  t = '{OP_AB1, OP_AC0, 1'b1, 1'b0, 1'b1, DST_N2};
      5'd6:  t = '{OP_QP0, OP_N0,  1'b0, 1'b1, 1'b0, DST_NONE};
      5'd7:  t = '{OP_QP1, OP_N1,  1'b0, 1'b0, 1'b0, DST_NONE};
      5'd8:  t = '{OP_QP2, OP_N2,  1'b0, 1'b0, 1'b1, DST_D};
      5'd9:  t = '{OP_AP0, OP_N0,  1'b0, 1'b1, 1'b0, DST_NONE};
      5'd10: t = '{OP_AP1, OP_N1,  1'b0, 1'b0, 1'b0, DST_NONE};
      5'd11: t = '{OP_AP2, OP_N2,  1'b0, 1'b0, 1'b1, DST_NUM};
      5'd12: t = '{OP_QP1, OP_AP2, 1'b0, 1'b1, 1'b0, DST_NONE};
      5'd13: t = '{OP_QP2, OP_AP1, 1'b1, 1'b0, 1'b1, DST_E0};
      5'd14: t = '{OP_QP2, OP_AP0, 1'b0, 1'b1, 1'b0, DST_NONE};
      5'd15: t = '{OP_QP0, OP_AP2, 1'b1, 1'b0, 1'b1, DST_E1};
      5'd16: t = '{OP_QP0, OP_AP1, 1'b0, 1'b1, 1'b0, DST_NONE};
      5'd17: t = '{OP_QP1, OP_AP0, 1'b1, 1'b0, 1'b1, DST_E2};
      5'd18: t = '{OP_AC0, OP_E0,  1'b0, 1'b1, 1'b0, DST_NONE};
      5'd19: t = '{OP_AC1, OP_E1,  1'b0, 1'b0, 1'b0, DST_NONE};
      5'd20: t = '{OP_AC2, OP_E2,  1'b0, 1'b0, 1'b1, DST_V};
      5'd21: t = '{OP_AB0, OP_E0,  1'b1, 1'b1, 1'b0, DST_NONE};
      5'd22: t = '{OP_AB1, OP_E1,  1'b1, 1'b0, 1'b0, DST_NONE};
      5'd23: t = '{OP_AB2, OP_E2,  1'b1, 1'b0, 1'b1, DST_W};
      default: t = '{OP_AB0, OP_AB0, 1'b0, 1'b1, 1'b0, DST_NONE};
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ----- design/stch_front.sv -----
`default_nettype none
module stch_front #(
  parameter int CW = stch_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [CW-1:0]                 in_a_x,
  input  wire logic signed [CW-1:0]                 in_a_y,
  input  wire logic signed [CW-1:0]                 in_a_z,
  input  wire logic signed [CW-1:0]                 in_b_x,
  input  wire logic signed [CW-1:0]                 in_b_y,
  input  wire logic signed [CW-1:0]                 in_b_z,
  input  wire logic signed [CW-1:0]                 in_c_x,
  input  wire logic signed [CW-1:0]                 in_c_y,
  input  wire logic signed [CW-1:0]                 in_c_z,
  input  wire logic                                 in_last_of_ray,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [stch_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CW-1:0]                        cfg_data,
  input  wire logic                                 q_full,
  output logic                                      q_push,
  output logic [12*(CW+1):0]                        q_data
);

  localparam int DW = CW + 1;

  logic signed [CW-1:0] start_r [3];
  logic signed [CW-1:0] end_r   [3];
  logic signed [DW-1:0] ab [3];
  logic signed [DW-1:0] ac [3];
  logic signed [DW-1:0] qp [3];
  logic signed [DW-1:0] ap [3];

  // Write segment end points
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        start_r[i] <= '0;
        end_r[i]   <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        stch_pkg::CFG_START_X: start_r[0] <= cfg_data;
        stch_pkg::CFG_START_Y: start_r[1] <= cfg_data;
        stch_pkg::CFG_START_Z: start_r[2] <= cfg_data;
        stch_pkg::CFG_END_X:   end_r[0]   <= cfg_data;
        stch_pkg::CFG_END_Y:   end_r[1]   <= cfg_data;
        stch_pkg::CFG_END_Z:   end_r[2]   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Form edge and segment differences
  always_comb begin
    ab[0] = DW'(in_b_x) - DW'(in_a_x);
    ab[1] = DW'(in_b_y) - DW'(in_a_y);
    ab[2] = DW'(in_b_z) - DW'(in_a_z);
    ac[0] = DW'(in_c_x) - DW'(in_a_x);
    ac[1] = DW'(in_c_y) - DW'(in_a_y);
    ac[2] = DW'(in_c_z) - DW'(in_a_z);
    ap[0] = DW'(start_r[0]) - DW'(in_a_x);
    ap[1] = DW'(start_r[1]) - DW'(in_a_y);
    ap[2] = DW'(start_r[2]) - DW'(in_a_z);
    for (int i = 0; i < 3; i++) begin
      qp[i] = DW'(start_r[i]) - DW'(end_r[i]);
    end
  end

  // Push one transaction per accepted triangle
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign q_data   = {in_last_of_ray, ap[2], ap[1], ap[0], qp[2], qp[1], qp[0],
                     ac[2], ac[1], ac[0], ab[2], ab[1], ab[0]};

endmodule
`default_nettype wire

// ----- design/stch_queue.sv -----
`default_nettype none
module stch_queue #(
  parameter int W = 12 * (stch_pkg::COORD_WIDTH_DEF + 1) + 1
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic              not_empty,
  output logic [W-1:0]      head
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wptr_r;
  logic [PW-1:0] rptr_r;
  logic [PW:0]   count_r;

  assign full      = (count_r == (PW+1)'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem[rptr_r];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) mem[wptr_r] <= push_data;
  end

endmodule
`default_nettype wire

// ----- design/stch_back.sv -----
`default_nettype none
module stch_back #(
  parameter int CW = stch_pkg::COORD_WIDTH_DEF,
  parameter int F  = stch_pkg::PARAM_FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire logic [12*(CW+1):0] q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_tri_hit,
  output logic [F:0]              out_tri_param,
  output logic                    out_any_hit,
  output logic [F:0]              out_best_param,
  output logic                    out_ray_done
);

  localparam int DW   = CW + 1;
  localparam int NW   = 2 * DW + 1;
  localparam int ACCW = 3 * DW + 2;
  localparam int K    = stch_pkg::DIGIT_BITS;
  localparam int ND   = (NW + K - 1) / K;
  localparam int DGW  = $clog2(ND);
  localparam int PW   = DW + K + 1;
  localparam int QW   = 12 * DW + 1;
  localparam int CNTW = $clog2(F + 1);
  localparam int TW   = stch_pkg::TERM_IDX_WIDTH;

  stch_pkg::bk_state_t state_r, state_nxt;
  stch_pkg::term_t     tcur;

  logic [TW-1:0]          term_r;
  logic [DGW-1:0]         dig_r;
  logic signed [DW-1:0]   a_r;
  logic [NW-1:0]          bmag_r;
  logic                   neg_r;
  logic signed [ACCW-1:0] acc_r, acc_nxt;
  logic signed [NW-1:0]   n_r [3];
  logic signed [NW-1:0]   e_r [3];
  logic signed [ACCW-1:0] d_r, num_r, v_r, w_r;
  logic [ACCW:0]          rem_r;
  logic [F:0]             q_r;
  logic                   hit_r;
  logic [CNTW-1:0]        cnt_r;
  logic [F:0]             nearest_r;
  logic                   seen_r;

  logic signed [DW-1:0]   a_pick;
  logic signed [NW-1:0]   b_full;
  logic [ND*K-1:0]        bpad;
  logic [K-1:0]           digit;
  logic signed [PW-1:0]   prod;
  logic signed [ACCW-1:0] shifted;
  logic                   dig_last;
  logic                   hit_c;
  logic                   full_c;
  logic signed [ACCW:0]   vw;
  logic [ACCW:0]          rem_sh;
  logic                   rem_ge;
  logic                   out_free;
  logic                   fire;
  logic [F:0]             one_param;

  assign tcur      = stch_pkg::term_entry(term_r);
  assign one_param = {1'b1, {F{1'b0}}};

  // Select the short operand
  always_comb begin
    unique case (tcur.a_sel)
      stch_pkg::OP_AB0: a_pick = q_data[0*DW +: DW];
      stch_pkg::OP_AB1: a_pick = q_data[1*DW +: DW];
      stch_pkg::OP_AB2: a_pick = q_data[2*DW +: DW];
      stch_pkg::OP_AC0: a_pick = q_data[3*DW +: DW];
      stch_pkg::OP_AC1: a_pick = q_data[4*DW +: DW];
      stch_pkg::OP_AC2: a_pick = q_data[5*DW +: DW];
      stch_pkg::OP_QP0: a_pick = q_data[6*DW +: DW];
      stch_pkg::OP_QP1: a_pick = q_data[7*DW +: DW];
      stch_pkg::OP_QP2: a_pick = q_data[8*DW +: DW];
      stch_pkg::OP_AP0: a_pick = q_data[9*DW +: DW];
      stch_pkg::OP_AP1: a_pick = q_data[10*DW +: DW];
      stch_pkg::OP_AP2: a_pick = q_data[11*DW +: DW];
      default:          a_pick = '0;
    endcase
  end

  // Select the long operand, sign extended
  always_comb begin
    unique case (tcur.b_sel)
      stch_pkg::OP_AC0: b_full = NW'($signed(q_data[3*DW +: DW]));
      stch_pkg::OP_AC1: b_full = NW'($signed(q_data[4*DW +: DW]));
      stch_pkg::OP_AC2: b_full = NW'($signed(q_data[5*DW +: DW]));
      stch_pkg::OP_AP0: b_full = NW'($signed(q_data[9*DW +: DW]));
      stch_pkg::OP_AP1: b_full = NW'($signed(q_data[10*DW +: DW]));
      stch_pkg::OP_AP2: b_full = NW'($signed(q_data[11*DW +: DW]));
      stch_pkg::OP_N0:  b_full = n_r[0];
      stch_pkg::OP_N1:  b_full = n_r[1];
      stch_pkg::OP_N2:  b_full = n_r[2];
      stch_pkg::OP_E0:  b_full = e_r[0];
      stch_pkg::OP_E1:  b_full = e_r[1];
      stch_pkg::OP_E2:  b_full = e_r[2];
      default:          b_full = '0;
    endcase
  end

  // One digit of the long operand per cycle
  assign bpad     = (ND*K)'(bmag_r);
  assign digit    = bpad[dig_r*K +: K];
  assign prod     = a_r * $signed({1'b0, digit});
  assign shifted  = ACCW'(prod) <<< (dig_r * K);
  assign acc_nxt  = neg_r ? (acc_r - shifted) : (acc_r + shifted);
  assign dig_last = (dig_r == DGW'(ND - 1));

  // Segment test on the finished sums
  assign vw    = (ACCW+1)'(v_r) + (ACCW+1)'(w_r);
  assign hit_c = !d_r[ACCW-1] && (d_r != '0)
              && !num_r[ACCW-1] && !(d_r < num_r)
              && !v_r[ACCW-1] && !(d_r < v_r)
              && !w_r[ACCW-1] && !((ACCW+1)'(d_r) < vw);
  assign full_c = !(num_r < d_r);

  // Restoring fraction division step
  assign rem_sh = {rem_r[ACCW-1:0], 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, d_r});

  assign out_free = !out_valid || out_ready;
  assign fire     = (state_r == stch_pkg::BK_FIN) && out_free;
  assign q_pop    = fire;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= stch_pkg::BK_IDLE;
    else        state_r <= state_nxt;
  end

  // Sequence terms, test, divide, deliver
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stch_pkg::BK_IDLE:  if (q_valid) state_nxt = stch_pkg::BK_LOAD;
      stch_pkg::BK_LOAD:  state_nxt = stch_pkg::BK_MUL;
      stch_pkg::BK_MUL: begin
        if (dig_last) begin
          if (term_r == TW'(stch_pkg::NUM_TERMS - 1)) state_nxt = stch_pkg::BK_CHECK;
          else                                        state_nxt = stch_pkg::BK_LOAD;
        end
      end
      stch_pkg::BK_CHECK: begin
        if (hit_c && !full_c) state_nxt = stch_pkg::BK_DIV;
        else                  state_nxt = stch_pkg::BK_FIN;
      end
      stch_pkg::BK_DIV:   if (cnt_r == CNTW'(F - 1)) state_nxt = stch_pkg::BK_FIN;
      stch_pkg::BK_FIN:   if (out_free) state_nxt = stch_pkg::BK_IDLE;
      default:            state_nxt = stch_pkg::BK_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      stch_pkg::BK_IDLE: term_r <= '0;
      stch_pkg::BK_LOAD: begin
        a_r    <= a_pick;
        neg_r  <= tcur.sub ^ b_full[NW-1];
        bmag_r <= b_full[NW-1] ? NW'(-b_full) : b_full;
        dig_r  <= '0;
        if (tcur.first) acc_r <= '0;
      end
      stch_pkg::BK_MUL: begin
        acc_r <= acc_nxt;
        dig_r <= dig_r + 1'b1;
        if (dig_last) begin
          term_r <= term_r + 1'b1;
          if (tcur.last) begin
            case (tcur.dst)
              stch_pkg::DST_N0:  n_r[0] <= acc_nxt[NW-1:0];
              stch_pkg::DST_N1:  n_r[1] <= acc_nxt[NW-1:0];
              stch_pkg::DST_N2:  n_r[2] <= acc_nxt[NW-1:0];
              stch_pkg::DST_E0:  e_r[0] <= acc_nxt[NW-1:0];
              stch_pkg::DST_E1:  e_r[1] <= acc_nxt[NW-1:0];
              stch_pkg::DST_E2:  e_r[2] <= acc_nxt[NW-1:0];
              stch_pkg::DST_D:   d_r    <= acc_nxt;
              stch_pkg::DST_NUM: num_r  <= acc_nxt;
              stch_pkg::DST_V:   v_r    <= acc_nxt;
              stch_pkg::DST_W:   w_r    <= acc_nxt;
              default: ;
            endcase
          end
        end
      end
      stch_pkg::BK_CHECK: begin
        hit_r <= hit_c;
        cnt_r <= '0;
        rem_r <= {1'b0, num_r};
        if (hit_c && full_c) q_r <= one_param;
        else                 q_r <= '0;
      end
      stch_pkg::BK_DIV: begin
        cnt_r <= cnt_r + 1'b1;
        rem_r <= rem_ge ? (rem_sh - {1'b0, d_r}) : rem_sh;
        q_r   <= {q_r[F-1:0], rem_ge};
      end
      default: ;
    endcase
  end

  // Running minimum and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
      nearest_r <= one_param;
      seen_r    <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (fire) begin
        out_valid <= 1'b1;
        if (q_data[QW-1]) begin
          nearest_r <= one_param;
          seen_r    <= 1'b0;
        end else begin
          seen_r <= seen_r | hit_r;
          if (hit_r && (q_r < nearest_r)) nearest_r <= q_r;
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_tri_hit    <= hit_r;
      out_tri_param  <= q_r;
      out_any_hit    <= seen_r | hit_r;
      out_best_param <= (hit_r && (q_r < nearest_r)) ? q_r : nearest_r;
      out_ray_done   <= q_data[QW-1];
    end
  end

endmodule
`default_nettype wire

// ----- design/segment_triangle_closest_hit_core.sv -----
`default_nettype none
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_a_x .. in_c_z, in_last_of_ray
// out      output     out_valid / out_ready  out_tri_hit, out_tri_param, out_any_hit,
//                                            out_best_param, out_ray_done
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The back end runs every product term on the shared multiply-accumulate unit, one digit
// per cycle (a digit is 16 bits of a 2*COORD_WIDTH+3 bit operand), and divides only when
// a triangle hits short of the segment end. A two-entry queue lets the front accept
// triangles while the back end works, and the output register holds a result while the
// next triangle computes.
// Reset is synchronous and clears the end points, the queue and the running minimum.
module segment_triangle_closest_hit_core #(
  parameter int COORD_WIDTH     = stch_pkg::COORD_WIDTH_DEF,
  parameter int PARAM_FRAC_BITS = stch_pkg::PARAM_FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [COORD_WIDTH-1:0]        in_a_x,
  input  wire logic signed [COORD_WIDTH-1:0]        in_a_y,
  input  wire logic signed [COORD_WIDTH-1:0]        in_a_z,
  input  wire logic signed [COORD_WIDTH-1:0]        in_b_x,
  input  wire logic signed [COORD_WIDTH-1:0]        in_b_y,
  input  wire logic signed [COORD_WIDTH-1:0]        in_b_z,
  input  wire logic signed [COORD_WIDTH-1:0]        in_c_x,
  input  wire logic signed [COORD_WIDTH-1:0]        in_c_y,
  input  wire logic signed [COORD_WIDTH-1:0]        in_c_z,
  input  wire logic                                 in_last_of_ray,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_tri_hit,
  output logic [PARAM_FRAC_BITS:0]                  out_tri_param,
  output logic                                      out_any_hit,
  output logic [PARAM_FRAC_BITS:0]                  out_best_param,
  output logic                                      out_ray_done,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [stch_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [COORD_WIDTH-1:0]               cfg_data
);

  localparam int QW = 12 * (COORD_WIDTH + 1) + 1;

  logic          q_full;
  logic          q_push;
  logic [QW-1:0] q_push_data;
  logic          q_pop;
  logic          q_not_empty;
  logic [QW-1:0] q_head;

  stch_front #(.CW(COORD_WIDTH)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_a_x         (in_a_x),
    .in_a_y         (in_a_y),
    .in_a_z         (in_a_z),
    .in_b_x         (in_b_x),
    .in_b_y         (in_b_y),
    .in_b_z         (in_b_z),
    .in_c_x         (in_c_x),
    .in_c_y         (in_c_y),
    .in_c_z         (in_c_z),
    .in_last_of_ray (in_last_of_ray),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_push_data)
  );

  stch_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  stch_back #(.CW(COORD_WIDTH), .F(PARAM_FRAC_BITS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_not_empty),
    .q_data         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tri_hit    (out_tri_hit),
    .out_tri_param  (out_tri_param),
    .out_any_hit    (out_any_hit),
    .out_best_param (out_best_param),
    .out_ray_done   (out_ray_done)
  );

endmodule
`default_nettype wire

// ----- test/segment_triangle_closest_hit_checker.sv -----
`default_nettype none
module segment_triangle_closest_hit_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [23:0] in_a_x,
  input  wire logic [23:0] in_a_y,
  input  wire logic [23:0] in_a_z,
  input  wire logic [23:0] in_b_x,
  input  wire logic [23:0] in_b_y,
  input  wire logic [23:0] in_b_z,
  input  wire logic [23:0] in_c_x,
  input  wire logic [23:0] in_c_y,
  input  wire logic [23:0] in_c_z,
  input  wire logic        in_last_of_ray,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        out_tri_hit,
  input  wire logic [16:0] out_tri_param,
  input  wire logic        out_any_hit,
  input  wire logic [16:0] out_best_param,
  input  wire logic        out_ray_done,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = stch_pkg::COORD_WIDTH_DEF;
  localparam int FB = stch_pkg::PARAM_FRAC_BITS_DEF;
  localparam logic [FB:0] PARAM_ONE = {1'b1, {FB{1'b0}}};

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic        hit;
    logic [FB:0] tparam;
    logic        any;
    logic [FB:0] best;
    logic        done;
  } hit_result_t;

  logic [CW-1:0] seg_reg [6];
  logic [FB:0]   nearest;
  logic          seen;
  hit_result_t   hit_q [$];

  function automatic wide_t sx(input logic [CW-1:0] r);
    return {{(128-CW){r[CW-1]}}, r};
  endfunction

  // Exact segment-triangle test; returns 1 on hit and the Q1.16 parameter
  function automatic logic seg_tri_test(input logic [CW-1:0] v[9], output logic [FB:0] t);
    wide_t p[3], q[3], a[3], b[3], c[3];
    wide_t ab[3], ac[3], qp[3], ap[3], n[3], e[3];
    wide_t d, num, vv, ww;
    t = '0;
    for (int i = 0; i < 3; i++) begin
      p[i] = sx(seg_reg[i]);
      q[i] = sx(seg_reg[3+i]);
      a[i] = sx(v[i]);
      b[i] = sx(v[3+i]);
      c[i] = sx(v[6+i]);
      ab[i] = b[i] - a[i];
      ac[i] = c[i] - a[i];
      qp[i] = p[i] - q[i];
      ap[i] = p[i] - a[i];
    end
    n[0] = ab[1]*ac[2] - ab[2]*ac[1];
    n[1] = ab[2]*ac[0] - ab[0]*ac[2];
    n[2] = ab[0]*ac[1] - ab[1]*ac[0];
    d = qp[0]*n[0] + qp[1]*n[1] + qp[2]*n[2];
    if (d <= 0) return 1'b0;
    num = ap[0]*n[0] + ap[1]*n[1] + ap[2]*n[2];
    if (num < 0 || num > d) return 1'b0;
    e[0] = qp[1]*ap[2] - qp[2]*ap[1];
    e[1] = qp[2]*ap[0] - qp[0]*ap[2];
    e[2] = qp[0]*ap[1] - qp[1]*ap[0];
    vv = ac[0]*e[0] + ac[1]*e[1] + ac[2]*e[2];
    if (vv < 0 || vv > d) return 1'b0;
    ww = -(ab[0]*e[0] + ab[1]*e[1] + ab[2]*e[2]);
    if (ww < 0 || vv + ww > d) return 1'b0;
    t = (FB+1)'((num <<< FB) / d);
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    logic [CW-1:0] v[9];
    logic [FB:0]   t;
    logic          h;
    hit_result_t   exp_r, got_r, pred_r;
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) seg_reg[i] = '0;
      nearest = PARAM_ONE;
      seen = 1'b0;
      hit_q.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      // track register writes; out-of-range indexes are dropped
      if (cfg_valid && cfg_ready && cfg_index <= stch_pkg::CFG_END_Z)
        seg_reg[cfg_index] = cfg_data;
      // compare each result transaction with the oldest prediction
      if (out_valid && out_ready) begin
        got_r = '{out_tri_hit, out_tri_param, out_any_hit, out_best_param, out_ray_done};
        if (hit_q.size() == 0) begin
          $display("%0t: unexpected result: actual hit=%0d t=%0d any=%0d best=%0d done=%0d",
                   $time, got_r.hit, got_r.tparam, got_r.any, got_r.best, got_r.done);
          errors <= errors + 1;
        end else begin
          exp_r = hit_q.pop_front();
          if (got_r !== exp_r) begin
            $display("%0t: mismatch: expected hit=%0d t=%0d any=%0d best=%0d done=%0d",
                     $time, exp_r.hit, exp_r.tparam, exp_r.any, exp_r.best, exp_r.done);
            $display("%0t:           actual   hit=%0d t=%0d any=%0d best=%0d done=%0d",
                     $time, got_r.hit, got_r.tparam, got_r.any, got_r.best, got_r.done);
            errors <= errors + 1;
          end
        end
      end
      // predict each triangle transaction
      if (in_valid && in_ready) begin
        v = '{in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z, in_c_x, in_c_y, in_c_z};
        h = seg_tri_test(v, t);
        if (h) begin
          seen = 1'b1;
          if (t < nearest) nearest = t;
        end
        pred_r = '{h, t, seen, nearest, in_last_of_ray};
        hit_q = {hit_q, pred_r};
        if (in_last_of_ray) begin
          nearest = PARAM_ONE;
          seen = 1'b0;
        end
      end
      pending <= hit_q.size();
    end
  end
endmodule
`default_nettype wire

// ----- test/segment_triangle_closest_hit_core_tb.sv -----
`default_nettype none
module segment_triangle_closest_hit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CMAX = 8388607;
  localparam int CMIN = -8388608;
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [23:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  } tri_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [23:0] in_a_x = '0, in_a_y = '0, in_a_z = '0;
  logic [23:0] in_b_x = '0, in_b_y = '0, in_b_z = '0;
  logic [23:0] in_c_x = '0, in_c_y = '0, in_c_z = '0;
  logic        in_last_of_ray = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_tri_hit, out_any_hit, out_ray_done;
  logic [16:0] out_tri_param, out_best_param;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  int          errors, pending;
  int          sent = 0;
  bit          quiet = 1'b0;
  int          seg_p[3], seg_q[3];
  tri_t        prev_tri = '0;

  always #6 clk = ~clk;

  segment_triangle_closest_hit_core i_dut (.*);

  segment_triangle_closest_hit_checker i_checker (.*);

  // Drop the run if it hangs
  initial begin
    #40ms;
    $display("Some tests failed");
    $finish;
  end

  // Stall the result channel in random bursts
  initial begin
    @(posedge clk iff rst_n);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [23:0] sat(input int x);
    return 24'(x > CMAX ? CMAX : (x < CMIN ? CMIN : x));
  endfunction

  function automatic int rnd_small(input int span);
    return int'($urandom_range(0, 2*span)) - span;
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [23:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_segment(input int p0, p1, p2, q0, q1, q2);
    seg_p = '{p0, p1, p2};
    seg_q = '{q0, q1, q2};
    cfg_write(stch_pkg::CFG_START_X, p0[23:0]);
    cfg_write(stch_pkg::CFG_START_Y, p1[23:0]);
    cfg_write(stch_pkg::CFG_START_Z, p2[23:0]);
    cfg_write(stch_pkg::CFG_END_X,   q0[23:0]);
    cfg_write(stch_pkg::CFG_END_Y,   q1[23:0]);
    cfg_write(stch_pkg::CFG_END_Z,   q2[23:0]);
    cfg_valid <= 1'b0;
  endtask

  // Hold off until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_tri(input tri_t t, input bit last);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    {in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z, in_c_x, in_c_y, in_c_z} <= t;
    in_last_of_ray <= last;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    prev_tri = t;
    sent++;
  endtask

  // Triangle centered on the point k/256 along the segment; flip swaps winding
  function automatic tri_t make_hit(input int k, input bit flip, input int span);
    int x[3], e1[3], e2[3];
    tri_t t;
    for (int i = 0; i < 3; i++) begin
      x[i]  = seg_p[i] + int'((longint'(seg_q[i] - seg_p[i]) * k) / 256);
      e1[i] = rnd_small(span);
      e2[i] = rnd_small(span);
    end
    t.ax = sat(x[0] - e1[0] - e2[0]);
    t.ay = sat(x[1] - e1[1] - e2[1]);
    t.az = sat(x[2] - e1[2] - e2[2]);
    t.bx = sat(x[0] + 2*e1[0] - e2[0]);
    t.by = sat(x[1] + 2*e1[1] - e2[1]);
    t.bz = sat(x[2] + 2*e1[2] - e2[2]);
    t.cx = sat(x[0] - e1[0] + 2*e2[0]);
    t.cy = sat(x[1] - e1[1] + 2*e2[1]);
    t.cz = sat(x[2] - e1[2] + 2*e2[2]);
    if (flip) begin
      {t.bx, t.by, t.bz, t.cx, t.cy, t.cz} = {t.cx, t.cy, t.cz, t.bx, t.by, t.bz};
    end
    return t;
  endfunction

  function automatic tri_t noise_tri();
    tri_t t;
    t = 216'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
              $urandom()});
    return t;
  endfunction

  // One ray of mostly well-formed triangles with some noise and repeats
  task automatic run_ray(input int n);
    int   kind, k;
    tri_t t;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 9);
      k = $urandom_range(0, 256);
      if ($urandom_range(0, 7) == 0) k = $urandom_range(0, 1) * 256;
      if (kind < 7) t = make_hit(k, $urandom_range(0, 1), $urandom_range(1, 16384));
      else if (kind == 7) t = prev_tri;
      else t = noise_tri();
      send_tri(t, i == n - 1);
    end
  endtask

  initial begin
    tri_t t;
    int   mode, goal;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // degenerate segment from reset: extreme triangles never hit
    seg_p = '{0, 0, 0};
    seg_q = '{0, 0, 0};
    send_tri({9{24'h7fffff}}, 1'b0);
    send_tri({9{24'h800000}}, 1'b0);
    send_tri({{3{24'h555555}}, {3{24'haaaaaa}}, {3{24'h000000}}}, 1'b0);
    send_tri(make_hit(128, 1'b0, 1000), 1'b1);
    drain();

    // spare indexes must not disturb the end points
    cfg_write(CFG_SPARE_LO, 24'h123456);
    cfg_write(CFG_SPARE_HI, 24'hfedcba);
    set_segment(100, -200, 4096, -50, 300, -4096);

    // endpoints, midpoint, equal parameters, both windings, degenerate triangle
    send_tri(make_hit(128, 1'b0, 2000), 1'b0);
    send_tri(prev_tri, 1'b0);
    send_tri(make_hit(256, 1'b0, 2000), 1'b0);
    send_tri(make_hit(256, 1'b1, 2000), 1'b0);
    send_tri(make_hit(0, 1'b0, 2000), 1'b0);
    send_tri(make_hit(0, 1'b1, 2000), 1'b0);
    send_tri(make_hit(64, 1'b0, 0), 1'b1);
    send_tri(make_hit(256, 1'b0, 3000), 1'b1);
    send_tri(make_hit(256, 1'b1, 3000), 1'b1);
    send_tri(make_hit(200, 1'b0, 3000), 1'b0);
    send_tri(make_hit(40, 1'b1, 3000), 1'b0);
    send_tri(make_hit(100, 1'b0, 3000), 1'b1);
    drain();

    // random phases, each with fresh end points
    while (sent < 1000) begin
      mode = $urandom_range(0, 7);
      if (mode == 0)
        set_segment(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
      else if (mode == 1)
        set_segment(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX);
      else if (mode == 2) begin
        t = noise_tri();
        set_segment(int'($signed(t.ax)), int'($signed(t.ay)), int'($signed(t.az)),
                    int'($signed(t.ax)), int'($signed(t.ay)), int'($signed(t.az)));
      end else
        set_segment(rnd_small(1 << 20), rnd_small(1 << 20), rnd_small(1 << 20),
                    rnd_small(1 << 20), rnd_small(1 << 20), rnd_small(1 << 20));
      if (sent > 900) quiet = 1'b1;
      goal = sent + 40;
      while (sent < goal) run_ray($urandom_range(1, 8));
      drain();
    end
    quiet = 1'b1;

    repeat (300) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
design/stch_pkg.sv
design/stch_front.sv
design/stch_queue.sv
design/stch_back.sv
design/segment_triangle_closest_hit_core.sv
test/segment_triangle_closest_hit_checker.sv
test/segment_triangle_closest_hit_core_tb.sv
